@@ hw/rtl/rar_pkg.sv @@
`default_nettype none

package rar_pkg;

	// Operand and result field widths.
	localparam int OPERAND_W = 8;
	localparam int RES_NUM_W = 16;
	localparam int RES_DEN_W = 15;

	// Raw cross-products: the numerator can reach a magnitude of 2^15 from
	// either side, so it needs one bit more than a single product.
	localparam int RAW_DEN_W = 2 * OPERAND_W;
	localparam int RAW_NUM_W = RAW_DEN_W + 1;

	// Unsigned magnitudes handled by the gcd and divide datapath.
	localparam int MAG_W   = 16;
	localparam int SHIFT_W = $clog2(MAG_W);

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef struct packed {
		logic signed [RAW_NUM_W-1:0] num;
		logic signed [RAW_DEN_W-1:0] den;
		logic                        num_zero;
		logic                        den_zero;
	} raw_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIV,
		BK_HOLD
	} back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/rar_front.sv @@
`default_nettype none

module rar_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            func,
	input  logic signed [rar_pkg::OPERAND_W-1:0]  a_num,
	input  logic signed [rar_pkg::OPERAND_W-1:0]  a_den,
	input  logic signed [rar_pkg::OPERAND_W-1:0]  b_num,
	input  logic signed [rar_pkg::OPERAND_W-1:0]  b_den,
	output logic                                  push,
	output rar_pkg::raw_item_t                    push_item,
	input  logic                                  full
);
	import rar_pkg::*;

	logic                          valid_s1;
	logic [1:0]                    func_s1;
	logic signed [RAW_DEN_W-1:0]   prod_x_s1;
	logic signed [RAW_DEN_W-1:0]   prod_y_s1;
	logic signed [RAW_DEN_W-1:0]   prod_d_s1;
	logic signed [OPERAND_W-1:0]   x_sel;
	logic signed [OPERAND_W-1:0]   d_sel;
	logic                          accept;
	logic signed [RAW_NUM_W-1:0]   ext_x;
	logic signed [RAW_NUM_W-1:0]   ext_y;
	logic signed [RAW_NUM_W-1:0]   raw_num;

	// Multiply takes the numerator product, divide swaps the second operand.
	assign x_sel = (func == FUNC_MUL) ? b_num : b_den;
	assign d_sel = (func == FUNC_DIV) ? b_num : b_den;

	assign in_stall = valid_s1 && full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			prod_x_s1 <= RAW_DEN_W'(a_num) * RAW_DEN_W'(x_sel);
			prod_y_s1 <= RAW_DEN_W'(b_num) * RAW_DEN_W'(a_den);
			prod_d_s1 <= RAW_DEN_W'(a_den) * RAW_DEN_W'(d_sel);
		end
	end

	assign ext_x = RAW_NUM_W'(prod_x_s1);
	assign ext_y = RAW_NUM_W'(prod_y_s1);

	always_comb begin
		case (func_s1)
			FUNC_ADD: begin
				raw_num = ext_x + ext_y;
			end
			FUNC_SUB: begin
				raw_num = ext_x - ext_y;
			end
			default: begin
				raw_num = ext_x;
			end
		endcase
	end

	assign push_item.num      = raw_num;
	assign push_item.den      = prod_d_s1;
	assign push_item.num_zero = (raw_num == '0);
	assign push_item.den_zero = (prod_d_s1 == '0);

endmodule

`default_nettype wire

@@ hw/rtl/rar_queue.sv @@
`default_nettype none

module rar_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rar_pkg::raw_item_t push_item,
	output logic               full,
	input  logic               pop,
	output rar_pkg::raw_item_t pop_item,
	output logic               empty
);
	import rar_pkg::*;

	raw_item_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
		logic [QPTR_W-1:0] nxt;
		if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rar_back.sv @@
`default_nettype none

module rar_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 empty,
	output logic                                 pop,
	input  rar_pkg::raw_item_t                   pop_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rar_pkg::RES_NUM_W-1:0] res_num,
	output logic signed [rar_pkg::RES_DEN_W-1:0] res_den,
	output logic                                 zero_den_error
);
	import rar_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	logic [MAG_W-1:0]     x_q;
	logic [MAG_W-1:0]     y_q;
	logic [MAG_W-1:0]     g_q;
	logic [MAG_W-1:0]     dvd_n_q;
	logic [MAG_W-1:0]     dvd_d_q;
	logic [MAG_W-1:0]     rem_n_q;
	logic [MAG_W-1:0]     rem_d_q;
	logic [SHIFT_W-1:0]   k_q;
	logic [SHIFT_W-1:0]   cnt_q;
	logic                 neg_q;
	logic [RES_NUM_W-1:0] pend_num_q;
	logic [RES_DEN_W-1:0] pend_den_q;
	logic                 pend_err_q;
	logic                 out_valid_q;
	logic [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0] res_den_q;
	logic                 res_err_q;

	logic                 special;
	logic                 gcd_done;
	logic                 both_even;
	logic                 div_last;
	logic                 out_load;
	logic [RAW_NUM_W-1:0] neg_num;
	logic [RAW_DEN_W-1:0] neg_den;
	logic [MAG_W-1:0]     mag_num;
	logic [MAG_W-1:0]     mag_den;
	logic [MAG_W-1:0]     x_d;
	logic [MAG_W-1:0]     y_d;
	logic [MAG_W:0]       step_n;
	logic [MAG_W:0]       step_d;
	logic [MAG_W-1:0]     quo_n_d;
	logic [MAG_W-1:0]     quo_d_d;
	logic [MAG_W-1:0]     signed_quo;

	// One restoring divide step: returns the new remainder and the quotient bit.
	function automatic logic [MAG_W:0] div_step(
		input logic [MAG_W-1:0] rem,
		input logic             bit_in,
		input logic [MAG_W-1:0] dvsr
	);
		logic [MAG_W:0] trial;
		logic [MAG_W:0] result;
		trial = {rem, bit_in};
		if (trial >= {1'b0, dvsr}) begin
			trial  = trial - {1'b0, dvsr};
			result = {trial[MAG_W-1:0], 1'b1};
		end else begin
			result = {trial[MAG_W-1:0], 1'b0};
		end
		return result;
	endfunction

	// Magnitudes of the raw values taken from the queue head.
	assign neg_num = -pop_item.num;
	assign neg_den = -pop_item.den;
	assign mag_num = pop_item.num[RAW_NUM_W-1] ? neg_num[MAG_W-1:0] : pop_item.num[MAG_W-1:0];
	assign mag_den = pop_item.den[RAW_DEN_W-1] ? neg_den[MAG_W-1:0] : pop_item.den[MAG_W-1:0];
	assign special = pop_item.num_zero || pop_item.den_zero;

	assign gcd_done  = (x_q == y_q);
	assign both_even = !x_q[0] && !y_q[0];
	assign div_last  = (cnt_q == SHIFT_W'(MAG_W - 1));

	// Binary gcd step; the even difference of two odd values is halved in the same cycle.
	always_comb begin
		x_d = x_q;
		y_d = y_q;
		if (both_even) begin
			x_d = x_q >> 1;
			y_d = y_q >> 1;
		end else if (!x_q[0]) begin
			x_d = x_q >> 1;
		end else if (!y_q[0]) begin
			y_d = y_q >> 1;
		end else if (x_q > y_q) begin
			x_d = (x_q - y_q) >> 1;
		end else begin
			y_d = (y_q - x_q) >> 1;
		end
	end

	assign step_n     = div_step(rem_n_q, dvd_n_q[MAG_W-1], g_q);
	assign step_d     = div_step(rem_d_q, dvd_d_q[MAG_W-1], g_q);
	assign quo_n_d    = {dvd_n_q[MAG_W-2:0], step_n[0]};
	assign quo_d_d    = {dvd_d_q[MAG_W-2:0], step_d[0]};
	assign signed_quo = neg_q ? (~quo_n_d + 1'b1) : quo_n_d;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = special ? BK_HOLD : BK_GCD;
				end
			end
			BK_GCD: begin
				if (gcd_done) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q        <= mag_num;
			y_q        <= mag_den;
			dvd_n_q    <= mag_num;
			dvd_d_q    <= mag_den;
			k_q        <= '0;
			neg_q      <= pop_item.num[RAW_NUM_W-1] ^ pop_item.den[RAW_DEN_W-1];
			pend_num_q <= pop_item.num[RES_NUM_W-1:0];
			pend_den_q <= pop_item.den[RES_DEN_W-1:0];
			pend_err_q <= pop_item.den_zero;
		end else if (state_q == BK_GCD) begin
			if (gcd_done) begin
				g_q     <= x_q << k_q;
				rem_n_q <= '0;
				rem_d_q <= '0;
				cnt_q   <= '0;
			end else begin
				x_q <= x_d;
				y_q <= y_d;
				if (both_even) begin
					k_q <= k_q + 1'b1;
				end
			end
		end else if (state_q == BK_DIV) begin
			rem_n_q <= step_n[MAG_W:1];
			rem_d_q <= step_d[MAG_W:1];
			dvd_n_q <= quo_n_d;
			dvd_d_q <= quo_d_d;
			cnt_q   <= cnt_q + 1'b1;
			if (div_last) begin
				pend_num_q <= signed_quo[RES_NUM_W-1:0];
				pend_den_q <= quo_d_d[RES_DEN_W-1:0];
				pend_err_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num_q <= pend_num_q;
			res_den_q <= pend_den_q;
			res_err_q <= pend_err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign res_num        = res_num_q;
	assign res_den        = res_den_q;
	assign zero_den_error = res_err_q;

endmodule

`default_nettype wire

@@ hw/rtl/rational_arith_reduce.sv @@
`default_nettype none

// Rational arithmetic unit with gcd reduction. Each input beat carries two
// signed 8-bit fractions a_num/a_den and b_num/b_den and an operation code
// (add, subtract, multiply, divide); each beat yields exactly one output beat
// holding the reduced fraction, with any negative sign moved onto res_num.
// A zero raw numerator is passed through as 0 over the raw, unreduced
// denominator; a zero raw denominator raises zero_den_error and leaves the
// raw numerator unreduced over a zero denominator. Results wrap to the field
// widths in two's complement. The front end registers the cross-products
// when a beat is taken, forms the raw fraction from those registers and
// writes it into a two-entry queue once the queue has room. The back end
// takes one item at a time: a binary gcd loop on the 16-bit magnitudes,
// one step per cycle, followed by a restoring division that divides
// numerator and denominator by the gcd side by side, and a hold state that
// hands the result to the output register. Items with a zero numerator or
// denominator skip the gcd loop and the division. The gcd loop and the
// divide steps set the sustained rate. Thanks to the queue and the output
// register, input beats keep being taken while a result waits to be
// collected, until the queue fills.
module rational_arith_reduce (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           func,
	input  logic signed [rar_pkg::OPERAND_W-1:0] a_num,
	input  logic signed [rar_pkg::OPERAND_W-1:0] a_den,
	input  logic signed [rar_pkg::OPERAND_W-1:0] b_num,
	input  logic signed [rar_pkg::OPERAND_W-1:0] b_den,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rar_pkg::RES_NUM_W-1:0] res_num,
	output logic signed [rar_pkg::RES_DEN_W-1:0] res_den,
	output logic                                 zero_den_error
);
	import rar_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	raw_item_t q_in_item;
	raw_item_t q_out_item;

	// Front end: operand selection, cross-products and raw fraction.
	rar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full)
	);

	// The queue lets the front keep taking beats while the back is busy.
	rar_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out_item),
		.empty     (q_empty)
	);

	// Back end: gcd, exact division, sign fix-up and the output register.
	rar_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (q_empty),
		.pop            (q_pop),
		.pop_item       (q_out_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.res_num        (res_num),
		.res_den        (res_den),
		.zero_den_error (zero_den_error)
	);

`ifndef NO_ASSERTIONS
	// An error result always carries a zero denominator.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_den_error |-> res_den == '0)
		else $error("zero_den_error without a zero res_den");

	// Without an error the denominator field is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_den_error |-> res_den != '0)
		else $error("res_den is zero on a result without error");

	// The back end only takes from a queue that holds something.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// The front end only writes when the queue has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");
`endif

endmodule

`default_nettype wire
